@@ rtl/memory_range_table_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the memory range table tracker
// Concurrent checks sampled on clk and disabled while arst_n is low; they
// expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEMORY_RANGE_TABLE_TRACKER_ASSERT_SVH
`define MEMORY_RANGE_TABLE_TRACKER_ASSERT_SVH
`ifndef SYNTH
`define MRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define MRT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MRT_ASSERT(lbl, prop, msg)
`define MRT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/mrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared sizes, status codes, page rounding and the command and status
// structs that join the tracker controller and datapath.
// ----------------------------------------------------------------------------
package mrt_pkg;

	// table and field sizes
	localparam int TABLE_ENTRIES = 64;
	localparam int PAGE_BITS     = 12;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W        = 48;
	localparam int LEN_W         = 41;
	localparam int END_W         = 49;
	localparam int SPAN_W        = 50;
	localparam int BYTES_W       = 64;
	localparam int EVT_W         = 32;
	localparam int STATUS_W      = 3;
	localparam int AREA_W        = 7;
	localparam int THR_W         = 41;

	localparam logic [THR_W-1:0]  THR_RESET = THR_W'(65536);
	localparam logic [SPAN_W-1:0] PAGE_MASK = SPAN_W'((64'd1 << PAGE_BITS) - 64'd1);

	// result status codes
	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BELOW   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FREED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISS    = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic round;
		logic span;
		logic test;
		logic scan;
		logic commit;
	} mrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic below;
		logic hit;
		logic scan_end;
		logic out_free;
	} mrt_stat_t;

	// round up to a multiple of the page size
	function automatic logic [SPAN_W-1:0] page_up(input logic [SPAN_W-1:0] v);
		page_up = (v + PAGE_MASK) & ~PAGE_MASK;
	endfunction

endpackage

@@ rtl/mrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer for one request: take it, round its ends, form the span, test the
// threshold, scan if not an allocation below it, commit once output is free.
// ----------------------------------------------------------------------------
module mrt_ctrl
	import mrt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mrt_stat_t stat,
	output mrt_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_SPAN,
		S_TEST,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_ROUND;
				end
				S_ROUND: state_q <= S_SPAN;
				S_SPAN:  state_q <= S_TEST;
				S_TEST: begin
					if (!stat.is_free && stat.below) state_q <= S_FINISH;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.hit || stat.scan_end) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// decode commands
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.round  = (state_q == S_ROUND);
		cmd.span   = (state_q == S_SPAN);
		cmd.test   = (state_q == S_TEST);
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_FINISH) && stat.out_free;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

@@ rtl/mrt_dpath.sv @@
// ----------------------------------------------------------------------------
// mrt_dpath
// Request registers, span arithmetic, range memory with registered read,
// active bits, running totals and the result register.
// ----------------------------------------------------------------------------
`include "memory_range_table_tracker_assert.svh"

module mrt_dpath
	import mrt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mrt_cmd_t            cmd,
	output mrt_stat_t           stat,
	input  logic                in_op,
	input  logic [ADDR_W-1:0]   in_address,
	input  logic [LEN_W-1:0]    in_length,
	input  logic                cfg_valid,
	input  logic [THR_W-1:0]    cfg_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STATUS_W-1:0] out_status,
	output logic [AREA_W-1:0]   out_area_count,
	output logic [BYTES_W-1:0]  out_bytes,
	output logic [EVT_W-1:0]    out_allocs,
	output logic [EVT_W-1:0]    out_frees
);

	// range memory
	logic [ADDR_W-1:0] mem_begin [TABLE_ENTRIES];
	logic [END_W-1:0]  mem_finish [TABLE_ENTRIES];

	logic [THR_W-1:0]         thr_q;
	logic                     op_q;
	logic [ADDR_W-1:0]        lo_q;
	logic [END_W-1:0]         hi_q;
	logic [SPAN_W-1:0]        rlo_q;
	logic [SPAN_W-1:0]        rhi_q;
	logic [SPAN_W-1:0]        span_q;
	logic                     below_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_slot_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         used_q;
	logic [TABLE_ENTRIES-1:0] active_q;
	logic [BYTES_W-1:0]       bytes_q;
	logic [EVT_W-1:0]         allocs_q;
	logic [EVT_W-1:0]         frees_q;
	logic                     out_valid_q;

	logic                     pend_s1;
	logic                     act_s1;
	logic [IDX_W-1:0]         slot_s1;
	logic [ADDR_W-1:0]        rb_s1;
	logic [END_W-1:0]         rf_s1;

	logic                     issue;
	logic                     cmp;
	logic                     hit;
	logic                     below;
	logic                     full;
	logic                     store_c;
	logic                     clear_c;
	logic [STATUS_W-1:0]      st_c;
	logic [BYTES_W:0]         sum_w;
	logic [BYTES_W-1:0]       bytes_nx;
	logic [CNT_W-1:0]         used_nx;
	logic [EVT_W-1:0]         allocs_nx;
	logic [EVT_W-1:0]         frees_nx;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// capture request, round ends, form span
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			lo_q  <= in_address;
			hi_q  <= END_W'(in_address) + END_W'(in_length);
			rlo_q <= page_up(SPAN_W'(in_address));
		end
		if (cmd.round) rhi_q <= page_up(SPAN_W'(hi_q));
		if (cmd.span) span_q <= rhi_q - rlo_q;
		if (cmd.test) below_q <= below;
	end

	assign below = span_q < SPAN_W'(thr_q);

	// scan: issue one read a cycle, compare the entry read the cycle before
	assign issue = cmd.scan && (idx_q < used_q);

	always_comb begin
		if (op_q) cmp = (rb_s1 <= lo_q) && (END_W'(lo_q) < rf_s1);
		else      cmp = (END_W'(rb_s1) < hi_q) && (END_W'(lo_q) < rf_s1);
	end

	assign hit = cmd.scan && pend_s1 && act_s1 && cmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else if (cmd.test) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else if (cmd.scan) begin
			pend_s1 <= issue;
			if (issue) idx_q <= idx_q + CNT_W'(1);
			if (hit) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s1 <= idx_q[IDX_W-1:0];
			act_s1  <= active_q[idx_q[IDX_W-1:0]];
		end
		if (hit) hit_slot_q <= slot_s1;
	end

	// memory write on store, registered read during scan
	always_ff @(posedge clk) begin
		if (cmd.commit && store_c) begin
			mem_begin[used_q[IDX_W-1:0]]  <= lo_q;
			mem_finish[used_q[IDX_W-1:0]] <= hi_q;
		end
		if (issue) begin
			rb_s1 <= mem_begin[idx_q[IDX_W-1:0]];
			rf_s1 <= mem_finish[idx_q[IDX_W-1:0]];
		end
	end

	// decide outcome and next totals
	assign full = (used_q == CNT_W'(TABLE_ENTRIES));

	always_comb begin
		st_c    = ST_MISS;
		store_c = 1'b0;
		clear_c = 1'b0;
		if (!op_q) begin
			if (below_q) begin
				st_c = ST_BELOW;
			end else if (hit_q) begin
				st_c = ST_OVERLAP;
			end else if (full) begin
				st_c = ST_FULL;
			end else begin
				st_c    = ST_STORED;
				store_c = 1'b1;
			end
		end else if (hit_q) begin
			st_c    = ST_FREED;
			clear_c = 1'b1;
		end
	end

	assign sum_w     = {1'b0, bytes_q} + (BYTES_W + 1)'(span_q);
	assign bytes_nx  = !store_c ? bytes_q : (sum_w[BYTES_W] ? '1 : sum_w[BYTES_W-1:0]);
	assign used_nx   = store_c ? used_q + CNT_W'(1) : used_q;
	assign allocs_nx = (!op_q && allocs_q != '1) ? allocs_q + EVT_W'(1) : allocs_q;
	assign frees_nx  = (op_q && frees_q != '1) ? frees_q + EVT_W'(1) : frees_q;

	// commit totals and active bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			bytes_q  <= '0;
			allocs_q <= '0;
			frees_q  <= '0;
			active_q <= '0;
		end else if (cmd.commit) begin
			used_q   <= used_nx;
			bytes_q  <= bytes_nx;
			allocs_q <= allocs_nx;
			frees_q  <= frees_nx;
			if (store_c) active_q[used_q[IDX_W-1:0]] <= 1'b1;
			if (clear_c) active_q[hit_slot_q] <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status     <= st_c;
			out_area_count <= AREA_W'(used_nx);
			out_bytes      <= bytes_nx;
			out_allocs     <= allocs_nx;
			out_frees      <= frees_nx;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat          = '0;
		stat.is_free  = op_q;
		stat.below    = below;
		stat.hit      = hit;
		stat.scan_end = (idx_q == used_q) && !pend_s1;
		stat.out_free = !out_valid_q || out_ready;
	end

	// checks
	`MRT_ASSERT(a_used_bound, used_q <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
	`MRT_ASSERT_IMPL(a_used_grows, cmd.commit && store_c, ##1 used_q == $past(used_q) + CNT_W'(1), "store did not advance entry count")
	`MRT_ASSERT_IMPL(a_read_in_range, pend_s1, CNT_W'(slot_s1) < used_q, "scan read an unwritten entry")
	`MRT_ASSERT_IMPL(a_hit_active, hit, active_q[slot_s1], "match on an obsolete entry")
	`MRT_ASSERT_IMPL(a_commit_slot, cmd.commit, !out_valid_q || out_ready, "result overwritten before taken")

endmodule

@@ rtl/memory_range_table_tracker.sv @@
// Memory range table tracker.
// Requests enter on the s_ channel: s_tuser is the operation (0 allocate,
// 1 free), s_tdata carries address and length. Every request gives exactly
// one result on the m_ channel: m_tuser is the status code, m_tdata the area
// count, byte total and the allocation and free counters after the request.
// The threshold register is written on the cfg channel, always ready.
// An allocation below the threshold skips the table scan; otherwise the scan
// covers the entries stored so far (at most 64) and stops early on a match.
// The table scan reads one entry a cycle through the range memory read port,
// and that scan sets the rate: one request at a time, the next accepted the
// cycle after the previous result is loaded.
// A loaded result waits in the output register while the next request is
// taken and worked on; that request then holds before commit until the
// receiver has taken the earlier result.
// Reset clears the active bits, counts and totals at once and restores the
// threshold to 65536; range memory needs no clearing pass since only
// written entries are scanned.
// ----------------------------------------------------------------------------
// memory_range_table_tracker
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module memory_range_table_tracker
	import mrt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // address [47:0], length [88:48], zero pad
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // area_count [6:0], area_bytes_total [70:7],
	                               // alloc_count [102:71], free_count [134:103], zero pad
	output logic [2:0]   m_tuser,  // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [40:0]  cfg_data  // area_threshold
);

	mrt_cmd_t           cmd;
	mrt_stat_t          stat;
	logic [AREA_W-1:0]  area_count;
	logic [BYTES_W-1:0] area_bytes;
	logic [EVT_W-1:0]   alloc_count;
	logic [EVT_W-1:0]   free_count;

	mrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_op          (s_tuser),
		.in_address     (s_tdata[47:0]),
		.in_length      (s_tdata[88:48]),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_status     (m_tuser),
		.out_area_count (area_count),
		.out_bytes      (area_bytes),
		.out_allocs     (alloc_count),
		.out_frees      (free_count)
	);

	// pack result fields, lowest first
	assign m_tdata   = {1'b0, free_count, alloc_count, area_bytes, area_count};
	assign cfg_ready = 1'b1;

endmodule
